// ===== design/cursor_doubly_linked_list_assert.svh =====
// ----------------------------------------------------------------------------
// cursor doubly linked list assertion macros
// concurrent checks clocked on i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef CURSOR_DOUBLY_LINKED_LIST_ASSERT_SVH
`define CURSOR_DOUBLY_LINKED_LIST_ASSERT_SVH

// same-cycle implication
`define CDLL_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cursor list check failed");

// next-cycle implication
`define CDLL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cursor list check failed");

`endif

// ===== design/cdll_pkg.sv =====
// ----------------------------------------------------------------------------
// cdll_pkg
// operation codes, status codes and transaction types of the cursor list
// ----------------------------------------------------------------------------
`default_nettype none

package cdll_pkg;

    localparam int KIND_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_FIRST        = 4'd0;
    localparam logic [KIND_W-1:0] KIND_NEXT         = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LAST         = 4'd2;
    localparam logic [KIND_W-1:0] KIND_PREV         = 4'd3;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_PUSH_AFTER   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_POP_BACK     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_POP_CURSOR   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_CLEAN        = 4'd10;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ELEM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_CURSOR = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value_in;
    } t_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  value_out;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

// ===== design/cdll_slot_alloc.sv =====
// ----------------------------------------------------------------------------
// cdll_slot_alloc
// finds the lowest free slot of the occupancy map, one-hot and encoded
// ----------------------------------------------------------------------------
`default_nettype none

module cdll_slot_alloc #(
    parameter int CAPACITY = 16
) (
    input  wire logic [CAPACITY-1:0]         i_occ,
    output logic                             o_full,
    output logic [CAPACITY-1:0]              o_onehot,
    output logic [$clog2(CAPACITY)-1:0]      o_slot
);

    localparam int SLOT_W = $clog2(CAPACITY);

    logic [CAPACITY-1:0] w_free;

    assign w_free   = ~i_occ;
    // isolate lowest set bit of the free map
    assign o_onehot = w_free & (~w_free + CAPACITY'(1));
    assign o_full   = ~|w_free;

    for (genvar b = 0; b < SLOT_W; b++) begin : g_enc
        logic [CAPACITY-1:0] w_mask;
        for (genvar i = 0; i < CAPACITY; i++) begin : g_bit
            assign w_mask[i] = 1'(i >> b);
        end
        assign o_slot[b] = |(o_onehot & w_mask);
    end

endmodule

`default_nettype wire

// ===== design/cursor_doubly_linked_list.sv =====
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list
// bounded doubly linked list of data words with head, tail and cursor
// ----------------------------------------------------------------------------
// One operation is taken at every clock edge where start is high; busy is
// never raised, so operations may follow back to back without a gap. Each
// operation is latched into an input register, executed in the following
// cycle by a single pass of logic over the node pool (held in flip-flops,
// with one data write, two writes per link table and one data read), and
// its result is registered at the end of that cycle and shown on o_result
// for exactly one cycle with o_strobe high; the strobe is registered
// together with the result. Throughput is one operation per cycle; the
// receiver has no way to stall the block and must take every result in
// the cycle it appears. The list state is updated at the same edge that
// loads the next operation, so each operation sees all earlier ones. Free
// nodes come from the lowest clear bit of the occupancy map; clean clears
// that map.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cursor_doubly_linked_list_assert.svh"

module cursor_doubly_linked_list #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire cdll_pkg::t_item   i_item,
    output logic                   busy,
    output logic                   o_strobe,
    output cdll_pkg::t_result      o_result
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int IDX_W  = $clog2(CAPACITY + 1);
    // slot number CAPACITY marks "no node" in head, tail, cursor and links
    localparam logic [IDX_W-1:0] NONE = IDX_W'(CAPACITY);

    // ---------------- input register ----------------
    logic              r_in_valid;
    cdll_pkg::t_item   r_in;

    // ---------------- list state ----------------
    logic [IDX_W-1:0]      r_head;
    logic [IDX_W-1:0]      r_tail;
    logic [IDX_W-1:0]      r_cursor;
    logic [CAPACITY-1:0]   r_occ;
    logic [DATA_WIDTH-1:0] r_value [CAPACITY];
    logic [IDX_W-1:0]      r_next  [CAPACITY];
    logic [IDX_W-1:0]      r_prev  [CAPACITY];

    // ---------------- result register ----------------
    logic                  r_strobe;
    cdll_pkg::t_result     r_result;

    // ---------------- next values ----------------
    logic [IDX_W-1:0]        n_head;
    logic [IDX_W-1:0]        n_tail;
    logic [IDX_W-1:0]        n_cursor;
    logic [CAPACITY-1:0]     n_occ;
    logic [cdll_pkg::STATUS_W-1:0] n_status;
    cdll_pkg::t_result       n_result;

    // pool write ports: one data write, two next-link and two prev-link writes
    logic                    val_we;
    logic [IDX_W-1:0]        val_addr;
    logic                    nl_we0, nl_we1, pl_we0, pl_we1;
    logic [IDX_W-1:0]        nl_a0, nl_a1, pl_a0, pl_a1;
    logic [IDX_W-1:0]        nl_d0, nl_d1, pl_d0, pl_d1;

    // data read port and result formatting
    logic                    show;
    logic [IDX_W-1:0]        rd_idx;
    logic [DATA_WIDTH-1:0]   rd_value;
    logic [DATA_WIDTH-1:0]   w_din;
    logic [cdll_pkg::VALUE_W-1:0] w_out_value;

    // free slot search
    logic                    alloc_full;
    logic [CAPACITY-1:0]     alloc_onehot;
    logic [SLOT_W-1:0]       alloc_slot;
    logic [IDX_W-1:0]        new_idx;

    function automatic logic f_is_node(input logic [IDX_W-1:0] idx);
        return idx < NONE;
    endfunction

    function automatic logic [SLOT_W-1:0] f_slot(input logic [IDX_W-1:0] idx);
        return idx[SLOT_W-1:0];
    endfunction

    // no internal back-pressure: busy is tied low
    assign busy = 1'b0;

    cdll_slot_alloc #(
        .CAPACITY (CAPACITY)
    ) u_alloc (
        .i_occ    (r_occ),
        .o_full   (alloc_full),
        .o_onehot (alloc_onehot),
        .o_slot   (alloc_slot)
    );

    assign new_idx = IDX_W'(alloc_slot);

    // stored word keeps the low DATA_WIDTH bits of the pushed word
    for (genvar b = 0; b < DATA_WIDTH; b++) begin : g_din
        if (b < cdll_pkg::VALUE_W) begin : g_bit
            assign w_din[b] = r_in.value_in[b];
        end else begin : g_pad
            assign w_din[b] = 1'b0;
        end
    end

    // single data read: node reached by a move or node being popped
    assign rd_value = r_value[f_slot(rd_idx)];

    // reported word is zero-extended, and zero when nothing was reached
    for (genvar b = 0; b < cdll_pkg::VALUE_W; b++) begin : g_out
        if (b < DATA_WIDTH) begin : g_bit
            assign w_out_value[b] = show & rd_value[b];
        end else begin : g_pad
            assign w_out_value[b] = 1'b0;
        end
    end

    // ---------------- execute stage ----------------
    always_comb begin
        logic             mv, ins, pop;
        logic [IDX_W-1:0] tgt, anchor, idx, succ, p, nx;

        mv       = 1'b0;
        ins      = 1'b0;
        pop      = 1'b0;
        tgt      = NONE;
        anchor   = NONE;
        idx      = NONE;
        succ     = NONE;
        p        = NONE;
        nx       = NONE;

        n_head   = r_head;
        n_tail   = r_tail;
        n_cursor = r_cursor;
        n_occ    = r_occ;
        n_status = cdll_pkg::ST_OK;
        show     = 1'b0;
        rd_idx   = NONE;

        val_we   = 1'b0;
        val_addr = new_idx;
        nl_we0   = 1'b0;
        nl_a0    = NONE;
        nl_d0    = NONE;
        nl_we1   = 1'b0;
        nl_a1    = NONE;
        nl_d1    = NONE;
        pl_we0   = 1'b0;
        pl_a0    = NONE;
        pl_d0    = NONE;
        pl_we1   = 1'b0;
        pl_a1    = NONE;
        pl_d1    = NONE;

        if (r_in_valid) begin
            case (r_in.kind)
                cdll_pkg::KIND_FIRST: begin
                    mv  = 1'b1;
                    tgt = r_head;
                end
                cdll_pkg::KIND_NEXT: begin
                    if (f_is_node(r_cursor)) begin
                        mv  = 1'b1;
                        tgt = r_next[f_slot(r_cursor)];
                    end else begin
                        n_status = cdll_pkg::ST_NO_ELEM;
                    end
                end
                cdll_pkg::KIND_LAST: begin
                    mv  = 1'b1;
                    tgt = r_tail;
                end
                cdll_pkg::KIND_PREV: begin
                    if (f_is_node(r_cursor)) begin
                        mv  = 1'b1;
                        tgt = r_prev[f_slot(r_cursor)];
                    end else begin
                        n_status = cdll_pkg::ST_NO_ELEM;
                    end
                end
                cdll_pkg::KIND_PUSH_FRONT: begin
                    if (alloc_full) begin
                        n_status = cdll_pkg::ST_FULL;
                    end else begin
                        val_we = 1'b1;
                        n_occ  = r_occ | alloc_onehot;
                        pl_we0 = 1'b1;
                        pl_a0  = new_idx;
                        pl_d0  = NONE;
                        nl_we0 = 1'b1;
                        nl_a0  = new_idx;
                        nl_d0  = r_head;
                        if (f_is_node(r_head)) begin
                            pl_we1 = 1'b1;
                            pl_a1  = r_head;
                            pl_d1  = new_idx;
                        end else begin
                            n_tail = new_idx;
                        end
                        n_head = new_idx;
                    end
                end
                cdll_pkg::KIND_PUSH_BACK: begin
                    ins    = 1'b1;
                    anchor = r_tail;
                end
                cdll_pkg::KIND_PUSH_AFTER: begin
                    // a non-empty list needs a cursor to insert after
                    if (!f_is_node(r_cursor) && f_is_node(r_head)) begin
                        n_status = cdll_pkg::ST_NO_CURSOR;
                    end else begin
                        ins    = 1'b1;
                        anchor = r_cursor;
                    end
                end
                cdll_pkg::KIND_POP_FRONT: begin
                    pop      = 1'b1;
                    idx      = r_head;
                    n_cursor = r_head;
                end
                cdll_pkg::KIND_POP_BACK: begin
                    pop      = 1'b1;
                    idx      = r_tail;
                    n_cursor = r_tail;
                end
                cdll_pkg::KIND_POP_CURSOR: begin
                    pop = 1'b1;
                    idx = r_cursor;
                end
                cdll_pkg::KIND_CLEAN: begin
                    n_occ    = '0;
                    n_head   = NONE;
                    n_tail   = NONE;
                    n_cursor = NONE;
                end
                default: begin
                end
            endcase

            // cursor moves
            if (mv) begin
                if (f_is_node(tgt)) begin
                    n_cursor = tgt;
                    rd_idx   = tgt;
                    show     = 1'b1;
                end else begin
                    n_status = cdll_pkg::ST_NO_ELEM;
                end
            end

            // insert after anchor, or as the only node when there is none
            if (ins) begin
                if (alloc_full) begin
                    n_status = cdll_pkg::ST_FULL;
                end else begin
                    val_we   = 1'b1;
                    n_occ    = r_occ | alloc_onehot;
                    n_cursor = new_idx;
                    if (!f_is_node(anchor)) begin
                        pl_we0 = 1'b1;
                        pl_a0  = new_idx;
                        pl_d0  = NONE;
                        nl_we0 = 1'b1;
                        nl_a0  = new_idx;
                        nl_d0  = NONE;
                        n_head = new_idx;
                        n_tail = new_idx;
                    end else begin
                        succ   = r_next[f_slot(anchor)];
                        pl_we0 = 1'b1;
                        pl_a0  = new_idx;
                        pl_d0  = anchor;
                        nl_we0 = 1'b1;
                        nl_a0  = new_idx;
                        nl_d0  = succ;
                        nl_we1 = 1'b1;
                        nl_a1  = anchor;
                        nl_d1  = new_idx;
                        if (f_is_node(succ)) begin
                            pl_we1 = 1'b1;
                            pl_a1  = succ;
                            pl_d1  = new_idx;
                        end else begin
                            n_tail = new_idx;
                        end
                    end
                end
            end

            // unlink and free the popped node, cursor goes to its successor
            if (pop) begin
                if (!f_is_node(idx)) begin
                    n_status = cdll_pkg::ST_NO_ELEM;
                end else begin
                    p      = r_prev[f_slot(idx)];
                    nx     = r_next[f_slot(idx)];
                    rd_idx = idx;
                    show   = 1'b1;
                    if (f_is_node(p)) begin
                        nl_we0 = 1'b1;
                        nl_a0  = p;
                        nl_d0  = nx;
                    end else begin
                        n_head = nx;
                    end
                    if (f_is_node(nx)) begin
                        pl_we0   = 1'b1;
                        pl_a0    = nx;
                        pl_d0    = p;
                        n_cursor = nx;
                    end else begin
                        n_tail   = p;
                        n_cursor = NONE;
                    end
                    n_occ[f_slot(idx)] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_result.value_out = w_out_value;
        n_result.status    = n_status;
    end

    // ---------------- control and list state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_strobe   <= 1'b0;
            r_head     <= NONE;
            r_tail     <= NONE;
            r_cursor   <= NONE;
            r_occ      <= '0;
        end else begin
            r_in_valid <= start & ~busy;
            r_strobe   <= r_in_valid;
            if (r_in_valid) begin
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_cursor <= n_cursor;
                r_occ    <= n_occ;
            end
        end
    end

    // ---------------- payload and node pool ----------------
    always_ff @(posedge i_clk) begin
        if (start & ~busy) begin
            r_in <= i_item;
        end
        if (r_in_valid) begin
            r_result <= n_result;
        end
        if (val_we) begin
            r_value[f_slot(val_addr)] <= w_din;
        end
        if (nl_we0) begin
            r_next[f_slot(nl_a0)] <= nl_d0;
        end
        if (nl_we1) begin
            r_next[f_slot(nl_a1)] <= nl_d1;
        end
        if (pl_we0) begin
            r_prev[f_slot(pl_a0)] <= pl_d0;
        end
        if (pl_we1) begin
            r_prev[f_slot(pl_a1)] <= pl_d1;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // ---------------- checks ----------------
    // every executed transaction yields exactly one result in the next cycle
    `CDLL_ASSERT_NEXT(a_result_follows, r_in_valid, o_strobe)
    `CDLL_ASSERT_NEXT(a_no_spurious_result, !r_in_valid, !o_strobe)
    // head and tail are both present or both absent
    `CDLL_ASSERT_IMPLY(a_ends_agree, 1'b1, ((r_head == NONE) == (r_tail == NONE)))
    // an empty pool holds no list and no cursor
    `CDLL_ASSERT_IMPLY(a_empty_pool, (r_occ == '0), ((r_head == NONE) && (r_cursor == NONE)))

endmodule

`default_nettype wire
